FILE: src/bfa_pkg.sv
package bfa_pkg;

  localparam int NUM_FRAMES = 131072;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = $clog2(MAP_WORDS);
  localparam int BIT_AW     = $clog2(WORD_BITS);
  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int PAGE_SHIFT = 12;
  localparam int MEM_AW     = FRAME_W + PAGE_SHIFT;

  // fixed field widths
  localparam int OP_W     = 2;
  localparam int ADDR_W   = 64;
  localparam int FADDR_W  = 29;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 18;
  localparam int CFG_W    = 18;
  localparam int CFG_IW   = 1;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_MAKE    = 2'd2;
  localparam logic [OP_W-1:0] OP_RESERVE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

  localparam logic [CFG_IW-1:0] REG_KFIRST = 1'd0;
  localparam logic [CFG_IW-1:0] REG_KLIMIT = 1'd1;

  typedef logic [WORD_BITS-1:0] map_word_t;

  function automatic logic [COUNT_W-1:0] popcount(input map_word_t v);
    logic [COUNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      c = c + COUNT_W'(v[i]);
    end
    return c;
  endfunction

endpackage

FILE: src/bfa_ram.sv
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/bitmap_frame_allocator_unit.sv
// Bitmap page-frame allocator for 4 KiB frames.
// Input channel (in_valid/in_ready): one beat carries an operation
// (alloc, free, make region available, reserve region), a byte address
// and a byte length. Output channel (out_valid/out_ready): exactly one beat
// per input beat with the allocated frame address, a status and the free
// frame count after the operation.
// Config port (cfg_we/cfg_index/cfg_data): kernel first/limit frame numbers;
// write only while the block is idle.
// The used/free map lives in one 4096 x 32 RAM with a registered read; every
// word visit is a read state followed by a modify/write state:
//   alloc   : scans from word 0 to the first word holding a free frame (all words on OOM)
//   free    : one word visit (none when rejected up front)
//   regions : setup and range steps, then a visit to every map word the region touches
// One item is in flight at a time; in_ready is high only when idle.
// Reset: a clearing pass over all 4096 map words writes all ones (every frame used)
// into the map; in_ready stays low until it finishes. The free count and the
// kernel range reset to zero.
// Stall: a finished result sits in the output register; if that register is
// still occupied when the next result is ready, the engine holds until the
// receiver takes the waiting beat.
module bitmap_frame_allocator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [bfa_pkg::OP_W-1:0]           in_operation,
  input  logic [bfa_pkg::ADDR_W-1:0]         in_address,
  input  logic [bfa_pkg::ADDR_W-1:0]         in_length,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bfa_pkg::FADDR_W-1:0]        out_frame_address,
  output logic [bfa_pkg::STATUS_W-1:0]       out_status,
  output logic [bfa_pkg::COUNT_W-1:0]        out_free_frames,
  input  logic                               cfg_we,
  input  logic [bfa_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [bfa_pkg::CFG_W-1:0]          cfg_data
);

  localparam logic [3:0] S_CLR       = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_SETUP     = 4'd2;
  localparam logic [3:0] S_RANGE     = 4'd3;
  localparam logic [3:0] S_RD        = 4'd4;
  localparam logic [3:0] S_MOD       = 4'd5;
  localparam logic [3:0] S_FREE_RD   = 4'd6;
  localparam logic [3:0] S_FREE_MOD  = 4'd7;
  localparam logic [3:0] S_ALLOC_RD  = 4'd8;
  localparam logic [3:0] S_ALLOC_MOD = 4'd9;
  localparam logic [3:0] S_DONE      = 4'd10;

  localparam int FW = bfa_pkg::FRAME_W + 1; // frame numbers incl. NUM_FRAMES
  localparam logic [FW-1:0] NFRAMES = FW'(bfa_pkg::NUM_FRAMES);
  localparam logic [bfa_pkg::WORD_AW-1:0] LAST_WORD = bfa_pkg::WORD_AW'(bfa_pkg::MAP_WORDS - 1);

  logic [3:0] state_r, state_nxt;
  logic [bfa_pkg::OP_W-1:0] op_r, op_nxt;
  logic [bfa_pkg::ADDR_W-1:0] addr_r, addr_nxt, len_r, len_nxt, end_r, end_nxt;
  logic [FW-1:0] first_r, first_nxt, last_r, last_nxt;
  logic [bfa_pkg::WORD_AW-1:0] w_r, w_nxt, lastw_r, lastw_nxt;
  logic [bfa_pkg::BIT_AW-1:0] bit_r, bit_nxt;
  logic [bfa_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [bfa_pkg::CFG_W-1:0] kfirst_r, klimit_r;
  logic [bfa_pkg::FADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [bfa_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [bfa_pkg::FADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [bfa_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [bfa_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  logic ram_we;
  bfa_pkg::map_word_t ram_wdata, ram_rdata, mask;
  logic [bfa_pkg::COUNT_W-1:0] pc;

  // scratch
  logic [bfa_pkg::ADDR_W:0] sum;
  logic [bfa_pkg::ADDR_W-1:0] endc, e2;
  logic [bfa_pkg::ADDR_W:0] sum2;
  logic [bfa_pkg::FRAME_W-1:0] in_frame;
  logic [FW-1:0] fr, last_m1;
  logic [bfa_pkg::BIT_AW-1:0] zbit;
  logic in_kernel_frame;

  bfa_ram #(
    .WIDTH(bfa_pkg::WORD_BITS),
    .DEPTH(bfa_pkg::MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(w_r),
    .wdata(ram_wdata),
    .raddr(w_r),
    .rdata(ram_rdata)
  );

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_frame_address = out_addr_r;
  assign out_status        = out_status_r;
  assign out_free_frames   = out_count_r;

  // per-bit region mask for the word being modified
  always_comb begin
    mask = '0;
    for (int b = 0; b < bfa_pkg::WORD_BITS; b++) begin
      fr = FW'({w_r, bfa_pkg::BIT_AW'(b)});
      if (fr >= first_r && fr < last_r) begin
        if (op_r == bfa_pkg::OP_MAKE) begin
          mask[b] = ram_rdata[b] &&
                    !(fr >= FW'(kfirst_r) && fr < FW'(klimit_r));
        end else begin
          mask[b] = !ram_rdata[b];
        end
      end
    end
    fr = '0;
  end

  assign pc = bfa_pkg::popcount(mask);

  // lowest free bit
  always_comb begin
    zbit = '0;
    for (int b = bfa_pkg::WORD_BITS - 1; b >= 0; b--) begin
      if (!ram_rdata[b]) zbit = bfa_pkg::BIT_AW'(b);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    len_nxt        = len_r;
    end_nxt        = end_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    w_nxt          = w_r;
    lastw_nxt      = lastw_r;
    bit_nxt        = bit_r;
    count_nxt      = count_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_wdata      = ram_rdata;
    sum            = '0;
    sum2           = '0;
    endc           = '0;
    e2             = '0;
    last_m1        = '0;
    in_frame       = in_address[bfa_pkg::MEM_AW-1:bfa_pkg::PAGE_SHIFT];
    in_kernel_frame = FW'(in_frame) >= FW'(kfirst_r) && FW'(in_frame) < FW'(klimit_r);

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = '1;
        w_nxt     = w_r + 1'b1;
        if (w_r == LAST_WORD) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_operation;
          addr_nxt       = in_address;
          len_nxt        = in_length;
          res_addr_nxt   = '0;
          res_status_nxt = bfa_pkg::ST_DONE;
          case (in_operation)
            bfa_pkg::OP_ALLOC: begin
              w_nxt     = '0;
              state_nxt = S_ALLOC_RD;
            end
            bfa_pkg::OP_FREE: begin
              w_nxt   = in_frame[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_AW];
              bit_nxt = in_frame[bfa_pkg::BIT_AW-1:0];
              if (in_address[bfa_pkg::PAGE_SHIFT-1:0] != '0 ||
                  in_address[bfa_pkg::ADDR_W-1:bfa_pkg::MEM_AW] != '0 ||
                  in_kernel_frame) begin
                res_status_nxt = bfa_pkg::ST_REJECT;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_FREE_RD;
              end
            end
            default: state_nxt = S_SETUP;
          endcase
        end
      end
      S_SETUP: begin
        // saturating base + length
        sum     = {1'b0, addr_r} + {1'b0, len_r};
        end_nxt = sum[bfa_pkg::ADDR_W] ? '1 : sum[bfa_pkg::ADDR_W-1:0];
        state_nxt = S_RANGE;
      end
      S_RANGE: begin
        if (op_r == bfa_pkg::OP_MAKE) begin
          endc = (end_r[bfa_pkg::ADDR_W-1:bfa_pkg::MEM_AW] != '0) ?
                 bfa_pkg::ADDR_W'(NFRAMES) << bfa_pkg::PAGE_SHIFT : end_r;
          first_nxt = FW'(addr_r[bfa_pkg::MEM_AW-1:bfa_pkg::PAGE_SHIFT]) +
                      FW'(addr_r[bfa_pkg::PAGE_SHIFT-1:0] != '0);
          last_nxt  = endc[bfa_pkg::MEM_AW:bfa_pkg::PAGE_SHIFT];
        end else begin
          // round the end up to a frame boundary, saturating
          sum2 = {1'b0, end_r} + (bfa_pkg::ADDR_W + 1)'((1 << bfa_pkg::PAGE_SHIFT) - 1);
          e2   = sum2[bfa_pkg::ADDR_W] ? '1 : sum2[bfa_pkg::ADDR_W-1:0];
          first_nxt = FW'(addr_r[bfa_pkg::MEM_AW-1:bfa_pkg::PAGE_SHIFT]);
          last_nxt  = (e2[bfa_pkg::ADDR_W-1:bfa_pkg::MEM_AW] != '0) ? NFRAMES :
                      FW'(e2[bfa_pkg::MEM_AW-1:bfa_pkg::PAGE_SHIFT]);
        end
        last_m1   = last_nxt - 1'b1;
        w_nxt     = first_nxt[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_AW];
        lastw_nxt = last_m1[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_AW];
        // base beyond memory or empty range: nothing to touch
        if (addr_r[bfa_pkg::ADDR_W-1:bfa_pkg::MEM_AW] != '0 || first_nxt >= last_nxt) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_MOD;
      S_MOD: begin
        ram_we = 1'b1;
        if (op_r == bfa_pkg::OP_MAKE) begin
          ram_wdata = ram_rdata & ~mask;
          count_nxt = count_r + pc;
        end else begin
          ram_wdata = ram_rdata | mask;
          count_nxt = (count_r >= pc) ? count_r - pc : '0;
        end
        if (w_r == lastw_r) begin
          state_nxt = S_DONE;
        end else begin
          w_nxt     = w_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_FREE_RD: state_nxt = S_FREE_MOD;
      S_FREE_MOD: begin
        if (ram_rdata[bit_r]) begin
          ram_we           = 1'b1;
          ram_wdata[bit_r] = 1'b0;
          count_nxt        = count_r + 1'b1;
        end else begin
          res_status_nxt = bfa_pkg::ST_REJECT;
        end
        state_nxt = S_DONE;
      end
      S_ALLOC_RD: state_nxt = S_ALLOC_MOD;
      S_ALLOC_MOD: begin
        if (ram_rdata != '1) begin
          ram_we          = 1'b1;
          ram_wdata[zbit] = 1'b1;
          if (count_r != '0) count_nxt = count_r - 1'b1;
          res_addr_nxt = bfa_pkg::FADDR_W'({w_r, zbit}) << bfa_pkg::PAGE_SHIFT;
          state_nxt    = S_DONE;
        end else if (w_r == LAST_WORD) begin
          res_status_nxt = bfa_pkg::ST_OOM;
          state_nxt      = S_DONE;
        end else begin
          w_nxt     = w_r + 1'b1;
          state_nxt = S_ALLOC_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      w_r         <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      kfirst_r    <= '0;
      klimit_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == bfa_pkg::REG_KFIRST) kfirst_r <= cfg_data;
      if (cfg_we && cfg_index == bfa_pkg::REG_KLIMIT) klimit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    len_r        <= len_nxt;
    end_r        <= end_nxt;
    first_r      <= first_nxt;
    last_r       <= last_nxt;
    lastw_r      <= lastw_nxt;
    bit_r        <= bit_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

FILE: src/bfa_checker.sv
module bfa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bfa_pkg::FADDR_W-1:0]  out_frame_address,
  input logic [bfa_pkg::STATUS_W-1:0] out_status,
  input logic [bfa_pkg::COUNT_W-1:0]  out_free_frames
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_address) &&
    $stable(out_status) && $stable(out_free_frames))
    else $error("result beat changed while stalled");

  a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bfa_pkg::ST_DONE |-> out_frame_address == '0)
    else $error("frame address on a failed operation");

  a_page_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_address[bfa_pkg::PAGE_SHIFT-1:0] == '0)
    else $error("unaligned frame address");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_free_frames <= bfa_pkg::COUNT_W'(bfa_pkg::NUM_FRAMES) &&
    out_status != 2'd3)
    else $error("free count or status out of range");

  // the clearing pass keeps input closed right after reset
  a_clear_pass: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during map clearing");

endmodule

bind bitmap_frame_allocator_unit bfa_checker u_bfa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_frame_address(out_frame_address),
  .out_status       (out_status),
  .out_free_frames  (out_free_frames)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bfa_pkg::*;

  localparam longint unsigned MEM_BYTES = longint'(NUM_FRAMES) << PAGE_SHIFT;
  localparam logic [63:0]     ALL_ONES  = '1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] len;
  } req_t;

  typedef struct packed {
    logic [FADDR_W-1:0]  faddr;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } rsp_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [OP_W-1:0] in_operation;
  logic [ADDR_W-1:0] in_address;
  logic [ADDR_W-1:0] in_length;
  logic out_valid;
  logic out_ready;
  logic [FADDR_W-1:0] out_frame_address;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0] out_free_frames;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bitmap_frame_allocator_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_address(in_address), .in_length(in_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_frame_address(out_frame_address), .out_status(out_status),
    .out_free_frames(out_free_frames),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow allocator state
  logic        frame_used [NUM_FRAMES];
  int unsigned shadow_free;
  logic [CFG_W-1:0] kern_first;
  logic [CFG_W-1:0] kern_limit;

  req_t pending_reqs[$];   // beats not yet offered
  rsp_t expected_rsps[$];  // predicted results, oldest first

  int  errors;
  bit  no_idle;            // set for the last stretch: no gaps, no stalls
  int  hold_req;           // request for a long receiver hold-off (cycles)
  int  op_seen [4];
  int  oom_seen;
  int  reject_seen;
  int  beats_out;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ALL_ONES : s[63:0];
  endfunction

  function automatic bit in_kernel(input logic [63:0] f);
    return f >= 64'(kern_first) && f < 64'(kern_limit);
  endfunction

  // apply one accepted beat to the shadow state and return the expected beat
  function automatic rsp_t alloc_predict(input req_t r);
    rsp_t        e;
    logic [63:0] first_f;
    logic [63:0] last_f;
    logic [63:0] end_b;
    logic [63:0] f;
    e = '0;
    case (r.op)
      OP_ALLOC: begin
        e.status = ST_OOM;
        for (int i = 0; i < NUM_FRAMES; i++) begin
          if (!frame_used[i]) begin
            frame_used[i] = 1'b1;
            if (shadow_free != 0) shadow_free--;
            e.faddr  = FADDR_W'(longint'(i) << PAGE_SHIFT);
            e.status = ST_DONE;
            break;
          end
        end
      end
      OP_FREE: begin
        f = r.addr >> PAGE_SHIFT;
        if (r.addr[PAGE_SHIFT-1:0] != 0 || f >= NUM_FRAMES || in_kernel(f) ||
            !frame_used[f[FRAME_W-1:0]]) begin
          e.status = ST_REJECT;
        end else begin
          frame_used[f[FRAME_W-1:0]] = 1'b0;
          shadow_free++;
          e.status = ST_DONE;
        end
      end
      OP_MAKE: begin
        if (r.addr < MEM_BYTES) begin
          end_b = sat_add(r.addr, r.len);
          if (end_b > MEM_BYTES) end_b = MEM_BYTES;
          first_f = (r.addr >> PAGE_SHIFT) + ((r.addr[PAGE_SHIFT-1:0] != 0) ? 1 : 0);
          last_f  = end_b >> PAGE_SHIFT;
          for (f = first_f; f < last_f; f++) begin
            if (!in_kernel(f) && frame_used[f[FRAME_W-1:0]]) begin
              frame_used[f[FRAME_W-1:0]] = 1'b0;
              shadow_free++;
            end
          end
        end
        e.status = ST_DONE;
      end
      default: begin
        first_f = r.addr >> PAGE_SHIFT;
        last_f  = sat_add(sat_add(r.addr, r.len), 64'hFFF) >> PAGE_SHIFT;
        if (last_f > NUM_FRAMES) last_f = NUM_FRAMES;
        for (f = first_f; f < last_f; f++) begin
          if (!frame_used[f[FRAME_W-1:0]]) begin
            frame_used[f[FRAME_W-1:0]] = 1'b1;
            if (shadow_free != 0) shadow_free--;
          end
        end
        e.status = ST_DONE;
      end
    endcase
    e.count = COUNT_W'(shadow_free);
    return e;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offers queued beats with random gaps; predicts on acceptance.
  // ---------------------------------------------------------------------
  int in_gap;
  always @(posedge clk) begin
    logic nxt_valid;
    req_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   = 0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        cur = '{in_operation, in_address, in_length};
        expected_rsps.push_back(alloc_predict(cur));
        op_seen[cur.op]++;
        nxt_valid = 1'b0;
        if (!no_idle && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 15);
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_reqs.size() != 0) begin
          cur = pending_reqs.pop_front();
          in_operation <= cur.op;
          in_address   <= cur.addr;
          in_length    <= cur.len;
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each result against the prediction; random stall bursts plus a long hold-off on each request.
  // ---------------------------------------------------------------------
  int out_stall;
  int hold_cnt;
  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
      hold_cnt  = 0;
    end else begin
      if (out_valid && out_ready) begin
        beats_out++;
        if (out_status == ST_OOM) oom_seen++;
        if (out_status == ST_REJECT) reject_seen++;
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat addr=%h status=%0d count=%0d", $time,
                   out_frame_address, out_status, out_free_frames);
        end else begin
          exp_r = expected_rsps.pop_front();
          if (out_frame_address !== exp_r.faddr) begin
            errors++;
            $display("%0t: frame_address expected %h actual %h", $time,
                     exp_r.faddr, out_frame_address);
          end
          if (out_status !== exp_r.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_status);
          end
          if (out_free_frames !== exp_r.count) begin
            errors++;
            $display("%0t: free_frames expected %0d actual %0d", $time,
                     exp_r.count, out_free_frames);
          end
        end
      end
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        if (!no_idle && $urandom_range(0, 5) == 0) out_stall = $urandom_range(1, 15);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_req(input logic [OP_W-1:0] op, input logic [63:0] a,
                          input logic [63:0] l);
    pending_reqs.push_back('{op, a, l});
  endtask

  // wait until every beat is offered, accepted and answered; sampled mid-cycle
  // so the clocked processes have settled
  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_kernel(input logic [CFG_W-1:0] first, input logic [CFG_W-1:0] limit);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KFIRST;
    cfg_data  <= first;
    @(posedge clk);
    cfg_index <= REG_KLIMIT;
    cfg_data  <= limit;
    kern_first = first;
    @(posedge clk);
    cfg_we    <= 1'b0;
    kern_limit = limit;
  endtask

  // random beat, mostly confined to the low 2048 frames so scans stay short
  task automatic push_random();
    int          r;
    int          sel;
    logic [63:0] fa;
    r  = $urandom_range(0, 99);
    fa = 64'($urandom_range(0, 2047)) << PAGE_SHIFT;
    if (r < 8) begin
      // wide noise: base far above memory, so regions stay cheap
      push_req(OP_W'($urandom_range(1, 3)), {1'b1, 31'($urandom), $urandom},
               {$urandom, $urandom});
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        push_req(OP_ALLOC, {$urandom, $urandom}, {$urandom, $urandom});
      end else if (sel < 60) begin
        if ($urandom_range(0, 9) == 0) fa[11:0] = 12'($urandom_range(1, 4095));
        if ($urandom_range(0, 29) == 0) fa = fa + MEM_BYTES;
        push_req(OP_FREE, fa, {$urandom, $urandom});
      end else if (sel < 82) begin
        if ($urandom_range(0, 3) == 0) fa[11:0] = 12'($urandom);
        push_req(OP_MAKE, fa, 64'($urandom_range(0, 64 * 4096)));
      end else begin
        if ($urandom_range(0, 3) == 0) fa[11:0] = 12'($urandom);
        push_req(OP_RESERVE, fa, 64'($urandom_range(0, 16 * 4096)));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_FRAMES; i++) frame_used[i] = 1'b1;
    shadow_free = 0;
    kern_first  = '0;
    kern_limit  = '0;
    errors      = 0;
    no_idle     = 1'b0;
    hold_req    = 0;
    oom_seen    = 0;
    reject_seen = 0;
    beats_out   = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = '0;
    in_address   = '0;
    in_length    = '0;
    out_ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty map, rejects, rounding, saturation, floor on reserve
    push_req(OP_ALLOC, 0, 0);                     // out of memory
    push_req(OP_FREE, 64'h1000, 0);               // used frame -> freed
    push_req(OP_FREE, 64'h1000, 0);               // already free
    push_req(OP_FREE, 64'h1001, 0);               // unaligned
    push_req(OP_FREE, MEM_BYTES, 0);              // past memory
    push_req(OP_FREE, ALL_ONES, ALL_ONES);
    push_req(OP_ALLOC, 0, 0);                     // gets frame 1 back
    push_req(OP_MAKE, 0, 0);                      // empty region
    push_req(OP_MAKE, 64'h1, 64'h3000);           // base rounded up
    push_req(OP_MAKE, MEM_BYTES, 64'h1000);       // base past memory
    push_req(OP_MAKE, 64'hFFFF_FFFF_FFFF_F000, ALL_ONES);
    push_req(OP_MAKE, 0, ALL_ONES);               // saturated, clipped: all free
    push_req(OP_ALLOC, 0, 0);                     // frame 0 at address 0
    push_req(OP_RESERVE, 64'h5000, 1);            // one frame
    push_req(OP_RESERVE, 64'h6001, 0);            // unaligned, zero length
    push_req(OP_RESERVE, 64'h7000, 0);            // aligned, zero length: nothing
    push_req(OP_RESERVE, ALL_ONES, ALL_ONES);     // beyond memory
    push_req(OP_RESERVE, 0, ALL_ONES);            // everything used again
    push_req(OP_ALLOC, 0, 0);
    hold_req = 300;                               // receiver sits out; input backs up
    drain();

    // kernel range in the low frames
    set_kernel(4, 8);
    push_req(OP_MAKE, 0, 64'h10000);              // skips frames 4..7
    push_req(OP_FREE, 64'h5000, 0);               // kernel frame
    push_req(OP_RESERVE, 64'h3000, 64'h3000);     // not skipped for reserve
    push_req(OP_ALLOC, 0, 0);
    push_req(OP_ALLOC, 0, 0);
    drain();

    // whole memory protected, then an empty kernel range at the end of memory
    set_kernel(0, 131072);
    push_req(OP_MAKE, 0, 64'h100000);
    push_req(OP_FREE, 64'h4000, 0);
    drain();
    set_kernel(131072, 131072);
    push_req(OP_MAKE, 64'h1_0000, 64'h8000);
    drain();

    // random phases over several kernel settings; the last one runs flat out
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_kernel(0, 0);
        1: set_kernel(100, 300);
        2: set_kernel(1500, 1600);
        default: set_kernel(131072, 0);
      endcase
      if (ph == 3) no_idle = 1'b1;
      for (int n = 0; n < 460; n++) push_random();
      if (ph == 1) hold_req = 400;
      drain();
    end

    $display("covered %0d alloc, %0d free, %0d make-available, %0d reserve beats",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("%0d results checked, %0d out of memory, %0d rejected frees",
             beats_out, oom_seen, reject_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1_500_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
